### design/ale_pkg.sv
// Package for the array list engine: command, status and cell control codes,
// plus default sizes and fixed field widths. No dependencies.

package ale_pkg;

  localparam int unsigned DepthDef   = 64;
  localparam int unsigned WidthDef   = 32;

  localparam int unsigned CmdW       = 4;
  localparam int unsigned ValW       = 32;
  localparam int unsigned PosW       = 6;
  localparam int unsigned CntOutW    = 7;
  localparam int unsigned StatW      = 3;
  localparam int unsigned InTdataW   = 48;
  localparam int unsigned OutTdataW  = 48;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_HEAD = 4'd0,
    CMD_POP_HEAD  = 4'd1,
    CMD_PUSH_TAIL = 4'd2,
    CMD_POP_TAIL  = 4'd3,
    CMD_INSERT    = 4'd4,
    CMD_DELETE    = 4'd5,
    CMD_REPLACE   = 4'd6,
    CMD_READ      = 4'd7,
    CMD_FIND      = 4'd8,
    CMD_DEL_VALUE = 4'd9
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  // what each cell does with its stored word this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_OPEN,   // make room: cells above the slot take the left neighbor
    CELL_CLOSE,  // remove: cells at and above the slot take the right neighbor
    CELL_LOAD    // overwrite the slot
  } cell_op_e;

  // what the search wave looks for
  typedef enum logic {
    SCAN_POS,
    SCAN_VAL
  } scan_kind_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    cell_op_e   op;
    scan_kind_e kind;
  } cell_ctrl_t;

endpackage

### design/ale_cell.sv
// One list cell: holds a single element and one stage of the search wave.
// Depends on ale_pkg.

module ale_cell import ale_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned WIDTH = WidthDef,
  parameter int unsigned INDEX = 0,
  localparam int unsigned IW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [IW-1:0]    at_i,
  input  logic [CW-1:0]    cnt_i,
  input  logic [WIDTH-1:0] value_i,
  input  logic [WIDTH-1:0] left_i,
  input  logic [WIDTH-1:0] right_i,
  output logic [WIDTH-1:0] data_o,
  input  logic             hit_i,
  input  logic [WIDTH-1:0] sdata_i,
  input  logic [IW-1:0]    spos_i,
  output logic             hit_o,
  output logic [WIDTH-1:0] sdata_o,
  output logic [IW-1:0]    spos_o
);

  localparam logic [IW-1:0] MyIdx = IW'(INDEX);
  localparam logic [CW-1:0] MyCnt = CW'(INDEX);

  logic [WIDTH-1:0] data_q, data_d;
  logic             hit_q, hit_d;
  logic [WIDTH-1:0] sdata_q, sdata_d;
  logic [IW-1:0]    spos_q, spos_d;
  logic             match;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_OPEN: begin
        if (MyIdx == at_i) begin
          data_d = value_i;
        end else if (MyIdx > at_i && MyCnt <= cnt_i) begin
          data_d = left_i;
        end
      end
      CELL_CLOSE: begin
        if (MyIdx >= at_i) begin
          data_d = right_i;
        end
      end
      CELL_LOAD: begin
        if (MyIdx == at_i) begin
          data_d = value_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // first hit from the head wins; later cells only forward it
  assign match = (ctrl_i.kind == SCAN_POS) ? (MyIdx == at_i)
                                           : (data_q == value_i && MyCnt < cnt_i);

  always_comb begin
    if (hit_i) begin
      hit_d   = 1'b1;
      sdata_d = sdata_i;
      spos_d  = spos_i;
    end else begin
      hit_d   = match;
      sdata_d = data_q;
      spos_d  = MyIdx;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    sdata_q <= sdata_d;
    spos_q  <= spos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign data_o  = data_q;
  assign hit_o   = hit_q;
  assign sdata_o = sdata_q;
  assign spos_o  = spos_q;

endmodule

### design/array_list_engine.sv
// Top level of the array list engine: command sequencer, result register and
// a chain of DEPTH ale_cell instances. Depends on ale_pkg and ale_cell.
//
//   channel   dir  beat contents (tdata, low bit first)
//   s_axis    in   cmd[3:0] value[35:4] position[41:36] zero[47:42]
//   m_axis    out  read_value[31:0] found_position[37:32] count[44:38] status[47:45]
//
// Push, insert, replace, unused codes and any refused command finish in the
// accept cycle: one beat per cycle while the result is not stalled. Pop,
// delete, read, find and delete value run a search wave down the cell chain,
// one cell per cycle; no new beat is taken until the wave is done. Reset empties the list; stored words are not
// cleared. A stalled result holds the output register; a new beat is taken
// only when the sequencer is idle and the result register is free or draining.

module array_list_engine import ale_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned WIDTH = WidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,   // cmd, value, position, pad
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o    // read_value, found_position, count, status
);

  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  fsm_e             state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    at_q, at_d;
  logic [WIDTH-1:0] val_q, val_d;
  scan_kind_e       kind_q, kind_d;
  logic             rm_q, rm_d;
  cmd_e             cmd_q, cmd_d;
  logic [IW-1:0]    timer_q, timer_d;

  logic             ovalid_q, ovalid_d;
  logic [WIDTH-1:0] ord_q, ord_d;
  logic [IW-1:0]    ofp_q, ofp_d;
  logic [CW-1:0]    ocnt_q, ocnt_d;
  status_e          ost_q, ost_d;

  cell_ctrl_t       ctrl;
  logic [IW-1:0]    at_bus;
  logic [WIDTH-1:0] val_bus;

  logic             accept;
  cmd_e             in_cmd;
  logic [WIDTH-1:0] in_val;
  logic [PosW-1:0]  in_pos;
  logic [CMPW-1:0]  posw, cntw;
  logic             full, empty;

  logic [WIDTH-1:0] cell_data [DEPTH];
  logic             chain_hit [DEPTH+1];
  logic [WIDTH-1:0] chain_data [DEPTH+1];
  logic [IW-1:0]    chain_pos [DEPTH+1];

  assign in_cmd = cmd_e'(s_axis_tdata_i[CmdW-1:0]);
  assign in_val = WIDTH'(s_axis_tdata_i[CmdW +: ValW]);
  assign in_pos = s_axis_tdata_i[CmdW+ValW +: PosW];
  assign posw   = CMPW'(in_pos);
  assign cntw   = CMPW'(cnt_q);
  assign full   = (cnt_q == FullCnt);
  assign empty  = (cnt_q == '0);

  assign s_axis_tready_o = (state_q == FSM_IDLE) && (!ovalid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    at_d     = at_q;
    val_d    = val_q;
    kind_d   = kind_q;
    rm_d     = rm_q;
    cmd_d    = cmd_q;
    timer_d  = timer_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    ord_d    = ord_q;
    ofp_d    = ofp_q;
    ocnt_d   = ocnt_q;
    ost_d    = ost_q;
    ctrl.op   = CELL_HOLD;
    ctrl.kind = kind_q;
    at_bus    = at_q;
    val_bus   = val_q;

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          // default result: no data, count unchanged, ok
          ovalid_d = 1'b1;
          ord_d    = '0;
          ofp_d    = '0;
          ocnt_d   = cnt_q;
          ost_d    = STAT_OK;
          case (in_cmd)
            CMD_PUSH_HEAD, CMD_PUSH_TAIL, CMD_INSERT: begin
              if (full) begin
                ost_d = STAT_FULL;
              end else if (in_cmd == CMD_INSERT && posw > cntw) begin
                ost_d = STAT_BADPOS;
              end else begin
                ctrl.op = CELL_OPEN;
                val_bus = in_val;
                if (in_cmd == CMD_PUSH_HEAD) begin
                  at_bus = '0;
                end else if (in_cmd == CMD_PUSH_TAIL) begin
                  at_bus = IW'(cnt_q);
                end else begin
                  at_bus = IW'(in_pos);
                end
                cnt_d  = CW'(cnt_q + 1'b1);
                ocnt_d = CW'(cnt_q + 1'b1);
              end
            end
            CMD_POP_HEAD, CMD_POP_TAIL, CMD_DELETE, CMD_REPLACE, CMD_READ: begin
              if (empty) begin
                ost_d = STAT_EMPTY;
              end else if ((in_cmd == CMD_DELETE || in_cmd == CMD_REPLACE) &&
                           posw >= cntw) begin
                ost_d = STAT_BADPOS;
              end else if (in_cmd == CMD_REPLACE) begin
                ctrl.op = CELL_LOAD;
                at_bus  = IW'(in_pos);
                val_bus = in_val;
              end else begin
                ovalid_d = ovalid_q && !m_axis_tready_i;
                if (in_cmd == CMD_POP_HEAD) begin
                  at_d = '0;
                end else if (in_cmd == CMD_POP_TAIL) begin
                  at_d = IW'(cnt_q - 1'b1);
                end else if (in_cmd == CMD_READ && posw >= cntw) begin
                  at_d = IW'(cnt_q - 1'b1);   // clamp to tail
                end else begin
                  at_d = IW'(in_pos);
                end
                kind_d  = SCAN_POS;
                rm_d    = (in_cmd != CMD_READ);
                cmd_d   = in_cmd;
                timer_d = IW'(DEPTH - 1);
                state_d = FSM_SCAN;
              end
            end
            CMD_FIND, CMD_DEL_VALUE: begin
              if (empty) begin
                ost_d = STAT_NOTFOUND;
              end else begin
                ovalid_d = ovalid_q && !m_axis_tready_i;
                val_d    = in_val;
                kind_d   = SCAN_VAL;
                rm_d     = (in_cmd == CMD_DEL_VALUE);
                cmd_d    = in_cmd;
                timer_d  = IW'(DEPTH - 1);
                state_d  = FSM_SCAN;
              end
            end
            default: ost_d = STAT_OK;
          endcase
        end
      end
      FSM_SCAN: begin
        // wait for the wave to reach the last cell
        timer_d = timer_q - 1'b1;
        if (timer_q == '0) begin
          state_d = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          ord_d    = '0;
          ofp_d    = '0;
          ocnt_d   = cnt_q;
          ost_d    = STAT_OK;
          if (kind_q == SCAN_VAL && !chain_hit[DEPTH]) begin
            ost_d = STAT_NOTFOUND;
          end else begin
            if (rm_q) begin
              ctrl.op = CELL_CLOSE;
              at_bus  = chain_pos[DEPTH];
              cnt_d   = CW'(cnt_q - 1'b1);
              ocnt_d  = CW'(cnt_q - 1'b1);
            end
            if (cmd_q != CMD_FIND) begin
              ord_d = chain_data[DEPTH];
            end
            if (cmd_q == CMD_FIND || cmd_q == CMD_DEL_VALUE) begin
              ofp_d = chain_pos[DEPTH];
            end
          end
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      kind_q   <= SCAN_POS;
      rm_q     <= 1'b0;
      cmd_q    <= CMD_READ;
      timer_q  <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      kind_q   <= kind_d;
      rm_q     <= rm_d;
      cmd_q    <= cmd_d;
      timer_q  <= timer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    at_q   <= at_d;
    val_q  <= val_d;
    ord_q  <= ord_d;
    ofp_q  <= ofp_d;
    ocnt_q <= ocnt_d;
    ost_q  <= ost_d;
  end

  assign chain_hit[0]  = 1'b0;
  assign chain_data[0] = '0;
  assign chain_pos[0]  = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WIDTH-1:0] left, right;
    if (g == 0) begin : g_head
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    ale_cell #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH),
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .at_i    (at_bus),
      .cnt_i   (cnt_q),
      .value_i (val_bus),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .hit_i   (chain_hit[g]),
      .sdata_i (chain_data[g]),
      .spos_i  (chain_pos[g]),
      .hit_o   (chain_hit[g+1]),
      .sdata_o (chain_data[g+1]),
      .spos_o  (chain_pos[g+1])
    );
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {ost_q, CntOutW'(ocnt_q), PosW'(ofp_q), ValW'(ord_q)};

endmodule

### tb/tb_top.sv
// Self-checking bench for array_list_engine: drives command beats on s_axis,
// predicts each reply from a shadow copy of the list and checks m_axis beats.
// Depends on ale_pkg and the array_list_engine RTL.

module tb_top;
  import ale_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = DepthDef;
  localparam int unsigned WIDTH = WidthDef;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam logic [CmdW-1:0] CmdUnusedLo = CmdW'(CMD_DEL_VALUE + 1);
  localparam logic [CmdW-1:0] CmdUnusedHi = '1;

  typedef struct packed {
    logic [ValW-1:0]    read_value;
    logic [PosW-1:0]    found_position;
    logic [CntOutW-1:0] count;
    status_e            status;
  } list_reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;   // cmd, value, position, pad
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;   // read_value, found_position, count, status

  // shadow list
  logic [ValW-1:0] list_words [DEPTH];
  int              list_len;
  list_reply_t     reply_q[$];

  int src_idle_pct;
  int sink_stall_pct;
  int err_cnt;
  int cycle_cnt;
  int cmd_beats;
  int peak_len;
  int status_seen [5];

  array_list_engine #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t timeout after %0d cycles, %0d replies outstanding",
               $realtime, cycle_cnt, reply_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // shadow list update; returns the reply the command should produce
  function automatic list_reply_t apply_list_cmd(logic [CmdW-1:0] cmd,
                                                 logic [ValW-1:0] val,
                                                 logic [PosW-1:0] pos);
    list_reply_t r;
    int          at;
    int          i;
    bit          hit;
    r = '0;
    r.status = STAT_OK;
    at = 0;
    hit = 1'b0;
    case (cmd)
      CMD_PUSH_HEAD, CMD_PUSH_TAIL, CMD_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = STAT_FULL;
        end else if (cmd == CMD_INSERT && int'(pos) > list_len) begin
          r.status = STAT_BADPOS;
        end else begin
          if (cmd == CMD_PUSH_TAIL) at = list_len;
          else if (cmd == CMD_INSERT) at = int'(pos);
          for (i = list_len; i > at; i--) list_words[i] = list_words[i-1];
          list_words[at] = val;
          list_len++;
        end
      end
      CMD_POP_HEAD, CMD_POP_TAIL, CMD_DELETE, CMD_REPLACE, CMD_READ: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else if (cmd == CMD_READ) begin
          at = (int'(pos) >= list_len) ? list_len - 1 : int'(pos);
          r.read_value = list_words[at];
        end else if ((cmd == CMD_DELETE || cmd == CMD_REPLACE) && int'(pos) >= list_len) begin
          r.status = STAT_BADPOS;
        end else if (cmd == CMD_REPLACE) begin
          list_words[pos] = val;
        end else begin
          if (cmd == CMD_POP_TAIL) at = list_len - 1;
          else if (cmd == CMD_DELETE) at = int'(pos);
          r.read_value = list_words[at];
          for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      CMD_FIND, CMD_DEL_VALUE: begin
        for (i = 0; i < list_len && !hit; i++) begin
          if (list_words[i] == val) begin
            hit = 1'b1;
            at = i;
          end
        end
        if (!hit) begin
          r.status = STAT_NOTFOUND;
        end else begin
          r.found_position = PosW'(at);
          if (cmd == CMD_DEL_VALUE) begin
            r.read_value = list_words[at];
            for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
            list_len--;
          end
        end
      end
      default: ;  // unused codes: count and ok only
    endcase
    r.count = CntOutW'(list_len);
    return r;
  endfunction

  // one command beat; entered and left just after a falling edge
  task automatic send_cmd(logic [CmdW-1:0] cmd, logic [ValW-1:0] val,
                          logic [PosW-1:0] pos);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= InTdataW'({$urandom, $urandom});
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InTdataW-CmdW-ValW-PosW){1'b0}}, pos, val, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    reply_q.push_back(apply_list_cmd(cmd, val, pos));
    cmd_beats++;
    if (list_len > peak_len) peak_len = list_len;
    @(negedge clk_i);
  endtask

  // hold the sender off until every reply is back
  task automatic drain_replies();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk_i);
  endtask

  // reply checker
  always @(posedge clk_i) begin
    list_reply_t want;
    list_reply_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.read_value     = m_axis_tdata[31:0];
      got.found_position = m_axis_tdata[37:32];
      got.count          = m_axis_tdata[44:38];
      got.status         = status_e'(m_axis_tdata[47:45]);
      if (got.status <= STAT_NOTFOUND) status_seen[got.status]++;
      if (reply_q.size() == 0) begin
        $display("%0t unexpected reply beat: expected none, actual %h",
                 $realtime, m_axis_tdata);
        err_cnt++;
      end else begin
        want = reply_q.pop_front();
        if (got.read_value !== want.read_value) begin
          $display("%0t read_value: expected %h actual %h",
                   $realtime, want.read_value, got.read_value);
          err_cnt++;
        end
        if (got.found_position !== want.found_position) begin
          $display("%0t found_position: expected %0d actual %0d",
                   $realtime, want.found_position, got.found_position);
          err_cnt++;
        end
        if (got.count !== want.count) begin
          $display("%0t count: expected %0d actual %0d",
                   $realtime, want.count, got.count);
          err_cnt++;
        end
        if (got.status !== want.status) begin
          $display("%0t status: expected %0d actual %0d",
                   $realtime, want.status, got.status);
          err_cnt++;
        end
      end
    end
  end

  // value biased toward stored words so searches hit
  function automatic logic [ValW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && list_len > 0) return list_words[$urandom_range(0, list_len - 1)];
    if (r < 65) return ValW'($urandom_range(0, 7));
    return $urandom;
  endfunction

  function automatic logic [PosW-1:0] pick_position();
    if ($urandom_range(0, 99) < 75) return PosW'($urandom_range(0, list_len));
    return PosW'($urandom_range(0, 63));
  endfunction

  function automatic logic [CmdW-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return CMD_PUSH_HEAD;
    if (r < 24) return CMD_PUSH_TAIL;
    if (r < 36) return CMD_INSERT;
    if (r < 44) return CMD_POP_HEAD;
    if (r < 52) return CMD_POP_TAIL;
    if (r < 61) return CMD_DELETE;
    if (r < 69) return CMD_REPLACE;
    if (r < 79) return CMD_READ;
    if (r < 88) return CMD_FIND;
    if (r < 97) return CMD_DEL_VALUE;
    return CmdW'($urandom_range(CmdUnusedLo, CmdUnusedHi));
  endfunction

  // empty-list cases, both ends, bad positions, clamped read, hits and misses
  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_cmd(CMD_POP_HEAD,  '0, '0);
    send_cmd(CMD_POP_TAIL,  '0, '0);
    send_cmd(CMD_DELETE,    '0, '0);
    send_cmd(CMD_REPLACE,   '1, '0);
    send_cmd(CMD_READ,      '0, '1);
    send_cmd(CMD_FIND,      '0, '0);
    send_cmd(CMD_DEL_VALUE, '0, '0);
    send_cmd(CMD_PUSH_HEAD, '0, '1);
    send_cmd(CMD_PUSH_TAIL, '1, '0);
    send_cmd(CMD_INSERT,    32'h1357_9bdf, '1);
    send_cmd(CMD_INSERT,    32'h1234_5678, 6'd2);
    send_cmd(CMD_INSERT,    32'ha5a5_a5a5, 6'd1);
    send_cmd(CMD_READ,      '0, '1);
    send_cmd(CMD_READ,      '0, '0);
    send_cmd(CMD_REPLACE,   32'hdead_beef, 6'd4);
    send_cmd(CMD_REPLACE,   32'h5a5a_5a5a, '0);
    send_cmd(CMD_FIND,      '1, '0);
    send_cmd(CMD_FIND,      32'h0000_0001, '0);
    send_cmd(CMD_DEL_VALUE, 32'ha5a5_a5a5, '0);
    send_cmd(CMD_DEL_VALUE, 32'h0000_0007, '0);
    send_cmd(CMD_DELETE,    '0, '1);
    send_cmd(CMD_DELETE,    '0, 6'd1);
    send_cmd(CmdUnusedLo,   '1, '1);
    send_cmd(CmdUnusedHi,   '1, '1);
    send_cmd(CMD_POP_TAIL,  '0, '0);
    send_cmd(CMD_POP_HEAD,  '0, '0);
  endtask

  // grow to capacity, hit the full cases, then drain back to empty
  task automatic test_full_list();
    int r;
    src_idle_pct   = 22;
    sink_stall_pct = 22;
    while (list_len < DEPTH) begin
      r = $urandom_range(0, 2);
      if (r == 0) send_cmd(CMD_PUSH_HEAD, $urandom, PosW'($urandom));
      else if (r == 1) send_cmd(CMD_PUSH_TAIL, $urandom, PosW'($urandom));
      else send_cmd(CMD_INSERT, $urandom, PosW'($urandom_range(0, list_len)));
    end
    send_cmd(CMD_PUSH_HEAD, $urandom, '0);
    send_cmd(CMD_PUSH_TAIL, $urandom, '0);
    send_cmd(CMD_INSERT, $urandom, '1);
    send_cmd(CMD_READ, '0, '1);
    send_cmd(CMD_FIND, list_words[DEPTH-1], '0);
    send_cmd(CMD_REPLACE, '1, '1);
    while (list_len > 0) begin
      r = $urandom_range(0, 3);
      if (r == 0) send_cmd(CMD_POP_HEAD, '0, '0);
      else if (r == 1) send_cmd(CMD_POP_TAIL, '0, '0);
      else if (r == 2) send_cmd(CMD_DELETE, '0, pick_position());
      else send_cmd(CMD_DEL_VALUE, pick_value(), '0);
    end
    drain_replies();
  endtask

  task automatic test_random_mix(int n_cmds, int idle_pct, int stall_pct);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    for (int k = 0; k < n_cmds; k++) begin
      send_cmd(pick_cmd(), pick_value(), pick_position());
      if (k % 150 == 149) drain_replies();
    end
    drain_replies();
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    err_cnt        = 0;
    cycle_cnt      = 0;
    cmd_beats      = 0;
    peak_len       = 0;
    list_len       = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_full_list();
    test_random_mix(300, 0, 0);
    test_random_mix(300, 69, 0);
    test_random_mix(300, 0, 69);
    test_random_mix(300, 22, 22);

    drain_replies();
    repeat (DEPTH + 8) @(negedge clk_i);

    $display("covered %0d command beats, all codes incl. unused, peak length %0d of %0d",
             cmd_beats, peak_len, DEPTH);
    $display("statuses ok/full/empty/badpos/notfound: %0d/%0d/%0d/%0d/%0d, %0d mismatches",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], err_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/ale_pkg.sv
design/ale_cell.sv
design/array_list_engine.sv
tb/tb_top.sv
